@@ rtl/dds2_pkg.sv @@
// ----------------------------------------------------------------------------
// dds2_pkg: shared types and constants for the dual channel sine generator
// Register indexes, reset values, DAC limits and the quarter-wave cosine
// evaluator used to build the lookup table at elaboration.
// ----------------------------------------------------------------------------
package dds2_pkg;

    typedef enum logic [1:0] {
        REG_PHASE_STEP_CH0 = 2'd0,
        REG_PHASE_STEP_CH1 = 2'd1,
        REG_GAIN_CH0       = 2'd2,
        REG_GAIN_CH1       = 2'd3
    } t_reg_idx;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned PHASE_W     = 32;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned DAC_W       = 12;
    localparam int unsigned IDX_OUT_W   = 6;
    localparam int unsigned COS_MAG_W   = 17;   // 0..32768
    localparam int unsigned COS_W       = 18;   // signed -32768..32768
    localparam int unsigned PROD_W      = 35;   // signed gain * cosine
    localparam int unsigned DIFF_W      = 36;

    localparam logic [PHASE_W-1:0] STEP_CH0_RST = 32'd42949673;
    localparam logic [PHASE_W-1:0] STEP_CH1_RST = 32'd42906723;
    localparam logic [GAIN_W-1:0]  GAIN_CH0_RST = 16'd32440;
    localparam logic [GAIN_W-1:0]  GAIN_CH1_RST = 16'd16384;

    // Midscale (2048 << 19) plus the rounding half (1 << 18).
    localparam logic signed [DIFF_W-1:0] DAC_BIAS = 36'sd1074003968;
    localparam logic [DAC_W-1:0]         DAC_MAX  = 12'd4095;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] K2      = 64'd1324675879;
    localparam logic [63:0] K4      = 64'd272375560;
    localparam logic [63:0] K6      = 64'd22401992;
    localparam logic [63:0] K8      = 64'd987048;
    localparam logic [63:0] K10     = 64'd27061;

    // cos(v*pi/2) for v in Q1.30 (0..1.0), result Q1.15. Elaboration only.
    function automatic logic [COS_MAG_W-1:0] quarter_cos(input logic [63:0] v);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] r;
        x2 = (v * v) >> 30;
        t  = K8 - ((x2 * K10) >> 30);
        t  = K6 - ((x2 * t) >> 30);
        t  = K4 - ((x2 * t) >> 30);
        t  = K2 - ((x2 * t) >> 30);
        s  = (x2 * t) >> 30;
        m  = (s >= Q30_ONE) ? 64'd0 : (Q30_ONE - s);
        r  = (m + 64'd16384) >> 15;
        return r[COS_MAG_W-1:0];
    endfunction

endpackage

@@ rtl/dds2_req_if.sv @@
// ----------------------------------------------------------------------------
// dds2_req_if: refill request channel
// Carries one refill request word: channel and buffer half.
// ----------------------------------------------------------------------------
interface dds2_req_if;
    logic valid;
    logic ready;
    logic channel;
    logic buffer_half;

    modport source (output valid, output channel, output buffer_half, input ready);
    modport sink   (input valid, input channel, input buffer_half, output ready);
endinterface

@@ rtl/dds2_smp_if.sv @@
// ----------------------------------------------------------------------------
// dds2_smp_if: sample channel
// Carries one DAC sample word with its buffer position.
// ----------------------------------------------------------------------------
interface dds2_smp_if;
    logic        valid;
    logic        ready;
    logic        out_channel;
    logic        out_half;
    logic [5:0]  sample_index;
    logic [11:0] sample_value;
    logic        last_sample;

    modport source (output valid, output out_channel, output out_half,
                    output sample_index, output sample_value, output last_sample,
                    input ready);
    modport sink   (input valid, input out_channel, input out_half,
                    input sample_index, input sample_value, input last_sample,
                    output ready);
endinterface

@@ rtl/dual_channel_dds_sine_block.sv @@
// ----------------------------------------------------------------------------
// dual_channel_dds_sine_block: two channel DDS sine generator for a 12-bit DAC
// Each refill request word yields SAMPLES_PER_BLOCK sample words, one per cycle
// unless stalled, from a per-channel 32-bit phase accumulator and a cosine table.
// ----------------------------------------------------------------------------
// Usage: a refill request names a channel and a buffer half. The block answers
// with SAMPLES_PER_BLOCK sample words (64 by default), one per clock while the
// sample sink keeps ready high. A request is taken during the cycle that issues
// the last sample of the previous block, so back-to-back requests stream without
// gaps. After its request is accepted, the first sample word of a block passes
// the issue, table read, multiply and saturate/output registers before it
// appears. Each sample is 2048 - gain * cos(phase) * 2048 in DAC codes, rounded
// half up and saturated to 0..4095; gain is unsigned Q1.15 (32768 = full scale,
// larger values are used as written). Phase wraps modulo 2^32 and advances by
// the channel's step after every sample; the top TABLE_ADDR_BITS phase bits
// address a quarter-wave cosine table built at elaboration. Requests naming a
// channel at or beyond CHANNEL_COUNT are accepted and dropped. Write the
// configuration registers only while no block is in flight.
// ----------------------------------------------------------------------------
module dual_channel_dds_sine_block
    import dds2_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_BLOCK = 64,
    parameter int unsigned TABLE_ADDR_BITS   = 10,
    parameter int unsigned CHANNEL_COUNT     = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dds2_req_if.sink              i_req,
    dds2_smp_if.source            o_smp
);

    localparam int unsigned CNT_W  = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
    localparam int unsigned QSTEPS = 1 << (TABLE_ADDR_BITS - 2);
    localparam int unsigned LI_W   = TABLE_ADDR_BITS - 1;   // table index 0..QSTEPS
    localparam int unsigned FRAC_W = TABLE_ADDR_BITS - 2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_BLOCK - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] r_step0, r_step1;
    logic [GAIN_W-1:0]  r_gain0, r_gain1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step0 <= STEP_CH0_RST;
            r_step1 <= STEP_CH1_RST;
            r_gain0 <= GAIN_CH0_RST;
            r_gain1 <= GAIN_CH1_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PHASE_STEP_CH0: r_step0 <= i_cfg_data;
                REG_PHASE_STEP_CH1: r_step1 <= i_cfg_data;
                REG_GAIN_CH0:       r_gain0 <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_CH1:       r_gain1 <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves unless the output word is stuck.
    // ------------------------------------------------------------------
    logic r3_valid;
    logic w_adv;
    assign w_adv = !r3_valid || o_smp.ready;

    // ------------------------------------------------------------------
    // Sequencer: holds the active request and counts its samples.
    // ------------------------------------------------------------------
    logic             r_busy;
    logic             r_ch;
    logic             r_half;
    logic [CNT_W-1:0] r_cnt;
    logic             w_issue;
    logic             w_issue_last;
    logic             w_accept;
    logic             w_ch_ok;

    assign w_issue      = r_busy && w_adv;
    assign w_issue_last = w_issue && (r_cnt == CNT_LAST);
    assign i_req.ready  = w_adv && (!r_busy || (r_cnt == CNT_LAST));
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_ch_ok      = (CHANNEL_COUNT > 1) || !i_req.channel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_issue_last) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            // a new request overrides the end of the previous block
            if (w_accept) begin
                r_busy <= w_ch_ok;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= i_req.channel;
            r_half <= i_req.buffer_half;
        end
    end

    // ------------------------------------------------------------------
    // Phase accumulators: advance the active channel on every issued sample.
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] r_acc [CHANNEL_COUNT];
    logic [PHASE_W-1:0] w_step;
    logic [PHASE_W-1:0] w_phase;
    logic [GAIN_W-1:0]  w_gain;

    assign w_step  = r_ch ? r_step1 : r_step0;
    assign w_gain  = r_ch ? r_gain1 : r_gain0;
    assign w_phase = (r_ch && (CHANNEL_COUNT > 1)) ? r_acc[CHANNEL_COUNT-1] : r_acc[0];

    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_acc
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc[c] <= '0;
            end else if (w_issue && (r_ch == 1'(c))) begin
                r_acc[c] <= r_acc[c] + w_step;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: issued sample, table address and gain.
    // ------------------------------------------------------------------
    logic                       r0_valid;
    logic [TABLE_ADDR_BITS-1:0] r0_addr;
    logic [GAIN_W-1:0]          r0_gain;
    logic                       r0_ch, r0_half, r0_last;
    logic [CNT_W-1:0]           r0_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_addr <= w_phase[PHASE_W-1 -: TABLE_ADDR_BITS];
            r0_gain <= w_gain;
            r0_ch   <= r_ch;
            r0_half <= r_half;
            r0_idx  <= r_cnt;
            r0_last <= (r_cnt == CNT_LAST);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: quarter-wave table read with quadrant folding.
    // ------------------------------------------------------------------
    logic [COS_MAG_W-1:0] w_lut [QSTEPS+1];

    for (genvar k = 0; k <= QSTEPS; k++) begin : g_lut
        localparam logic [COS_MAG_W-1:0] LutVal = quarter_cos(64'(k) << (32 - TABLE_ADDR_BITS));
        assign w_lut[k] = LutVal;
    end

    logic [1:0]           w_quad;
    logic [LI_W-1:0]      w_frac;
    logic [LI_W-1:0]      w_li;
    logic [COS_MAG_W-1:0] w_mag;
    logic                 w_neg;
    logic signed [COS_W-1:0] n1_cos;

    assign w_quad = r0_addr[TABLE_ADDR_BITS-1 -: 2];
    assign w_frac = LI_W'(r0_addr[FRAC_W-1:0]);
    // odd quadrants read the mirrored position
    assign w_li   = w_quad[0] ? (LI_W'(QSTEPS) - w_frac) : w_frac;
    assign w_mag  = w_lut[w_li];
    assign w_neg  = w_quad[1] ^ w_quad[0];
    assign n1_cos = w_neg ? -signed'(COS_W'(w_mag)) : signed'(COS_W'(w_mag));

    logic                    r1_valid;
    logic signed [COS_W-1:0] r1_cos;
    logic [GAIN_W-1:0]       r1_gain;
    logic                    r1_ch, r1_half, r1_last;
    logic [CNT_W-1:0]        r1_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_cos  <= n1_cos;
            r1_gain <= r0_gain;
            r1_ch   <= r0_ch;
            r1_half <= r0_half;
            r1_idx  <= r0_idx;
            r1_last <= r0_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: gain times cosine, exact.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] n2_prod;
    logic                     r2_valid;
    logic signed [PROD_W-1:0] r2_prod;
    logic                     r2_ch, r2_half, r2_last;
    logic [CNT_W-1:0]         r2_idx;

    assign n2_prod = PROD_W'(signed'({1'b0, r1_gain})) * PROD_W'(r1_cos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_prod <= n2_prod;
            r2_ch   <= r1_ch;
            r2_half <= r1_half;
            r2_idx  <= r1_idx;
            r2_last <= r1_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: offset, round, saturate into the output register.
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] w_diff;
    logic [DAC_W-1:0]         n3_code;

    assign w_diff = DAC_BIAS - DIFF_W'(r2_prod);

    always_comb begin
        if (w_diff[DIFF_W-1]) begin
            n3_code = '0;
        end else if (|w_diff[DIFF_W-2:DAC_W+19]) begin
            n3_code = DAC_MAX;
        end else begin
            n3_code = w_diff[DAC_W+18:19];
        end
    end

    logic             r3_ch, r3_half, r3_last;
    logic [CNT_W-1:0] r3_idx;
    logic [DAC_W-1:0] r3_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_code <= n3_code;
            r3_ch   <= r2_ch;
            r3_half <= r2_half;
            r3_idx  <= r2_idx;
            r3_last <= r2_last;
        end
    end

    assign o_smp.valid        = r3_valid;
    assign o_smp.out_channel  = r3_ch;
    assign o_smp.out_half     = r3_half;
    assign o_smp.sample_index = IDX_OUT_W'(r3_idx);
    assign o_smp.sample_value = r3_code;
    assign o_smp.last_sample  = r3_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the last-sample flag marks exactly the final block position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_smp.valid |-> (o_smp.last_sample == (o_smp.sample_index ==
                         IDX_OUT_W'(SAMPLES_PER_BLOCK - 1))))
        else $error("last_sample does not match final sample index");

    // a request is taken mid-block only as the last sample issues
    a_accept_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_busy) |-> w_issue_last)
        else $error("request accepted while block still issuing");

    // a stalled output register freezes the sequencer
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_adv && !w_accept) |=> (r_busy && $stable(r_cnt)))
        else $error("sequencer moved during output stall");

endmodule
